// ----- hdl/jpeg_huffman_table_segment_parser_defines.svh -----
// Shared assertion macros for the DHT segment parser.
// All of them sample on aclk and are off while aresetn is low.
`ifndef JPEG_HUFFMAN_TABLE_SEGMENT_PARSER_DEFINES_SVH
`define JPEG_HUFFMAN_TABLE_SEGMENT_PARSER_DEFINES_SVH

// Same-cycle implication.
`define JHTSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JHTSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/jhtsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jhtsp_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_SLOTS_DEF = 4;
    localparam int MAX_SYMBOLS_DEF = 256;

    // Segment layout
    localparam int NUM_COUNTS  = 16;
    localparam int AC_BIT_POS  = 4;
    localparam int LEN_HDR     = 2;

    // Result status codes
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;
    localparam logic [1:0] ST_NOTE = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TOO_MANY  = 3'd1;
    localparam logic [2:0] ERR_OVERRUN   = 3'd2;
    localparam logic [2:0] ERR_BAD_SLOT  = 3'd3;
    localparam logic [2:0] ERR_TRAILING  = 3'd4;
    localparam logic [2:0] ERR_SHORT_LEN = 3'd5;

    typedef struct packed {
        logic       cmd;
        logic [7:0] seg_byte;
        logic       seg_start;
        logic       rd_class;
        logic [1:0] rd_slot;
        logic       rd_kind;
        logic [7:0] rd_pos;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] error_code;
        logic [7:0] rd_value;
        logic       rd_present;
    } out_beat_t;

    // Strobes from the parser into the table store
    typedef struct packed {
        logic cnt_we;
        logic sym_we;
        logic commit;
        logic rd_en;
    } store_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/jhtsp_table_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "jpeg_huffman_table_segment_parser_defines.svh"

// Double-banked table store. Each table owns two banks; a table being
// parsed is written into the bank not in use, and a commit flips the bank.
module jhtsp_table_store #(
    parameter int TABLE_SLOTS = jhtsp_pkg::TABLE_SLOTS_DEF,
    localparam int NT         = 2 * TABLE_SLOTS,
    localparam int TW         = $clog2(NT)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire jhtsp_pkg::store_ctl_t  ctl,
    input  wire logic [TW-1:0]          wr_tbl,
    input  wire logic [3:0]             wr_cidx,
    input  wire logic [7:0]             wr_spos,
    input  wire logic [7:0]             wr_data,
    input  wire logic [TW-1:0]          rd_tbl,
    input  wire logic [3:0]             rd_cidx,
    input  wire logic [7:0]             rd_spos,
    output logic [7:0]                  rd_cnt,
    output logic [7:0]                  rd_sym,
    output logic                        rd_present
);
    import jhtsp_pkg::*;

    localparam int CNT_DEPTH = NT * 32;
    localparam int SYM_DEPTH = NT * 512;

    logic [7:0]    cnt_mem [CNT_DEPTH];
    logic [7:0]    sym_mem [SYM_DEPTH];
    logic [NT-1:0] bank_reg;
    logic [NT-1:0] present_reg;

    logic          wr_bank;
    logic          rd_bank;
    logic [TW+4:0] cnt_waddr;
    logic [TW+4:0] cnt_raddr;
    logic [TW+8:0] sym_waddr;
    logic [TW+8:0] sym_raddr;

    // Writes go to the idle bank, reads to the committed one
    assign wr_bank   = ~bank_reg[wr_tbl];
    assign rd_bank   = bank_reg[rd_tbl];
    assign cnt_waddr = {wr_tbl, wr_bank, wr_cidx};
    assign cnt_raddr = {rd_tbl, rd_bank, rd_cidx};
    assign sym_waddr = {wr_tbl, wr_bank, wr_spos};
    assign sym_raddr = {rd_tbl, rd_bank, rd_spos};

    // Bank select and presence bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg    <= '0;
            present_reg <= '0;
        end else if (ctl.commit) begin
            bank_reg[wr_tbl]    <= ~bank_reg[wr_tbl];
            present_reg[wr_tbl] <= 1'b1;
        end
    end

    // Count memory
    always_ff @(posedge aclk) begin
        if (ctl.cnt_we) begin
            cnt_mem[cnt_waddr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_cnt <= cnt_mem[cnt_raddr];
        end
    end

    // Symbol memory
    always_ff @(posedge aclk) begin
        if (ctl.sym_we) begin
            sym_mem[sym_waddr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_sym     <= sym_mem[sym_raddr];
            rd_present <= present_reg[rd_tbl];
        end
    end

    `JHTSP_ASSERT_NXT(a_commit_sets_present, ctl.commit, present_reg[$past(wr_tbl)],
        "committed table not marked present")
    `JHTSP_ASSERT_IMP(a_read_not_with_write, ctl.rd_en,
        !(ctl.cnt_we || ctl.sym_we || ctl.commit), "table read collides with parser write")
    `JHTSP_ASSERT_IMP(a_single_mem_write, ctl.cnt_we, !ctl.sym_we,
        "count and symbol writes in the same cycle")

endmodule

`default_nettype wire

// ----- hdl/jpeg_huffman_table_segment_parser.sv -----
// DHT segment parser with 2*TABLE_SLOTS stored Huffman tables (DC and AC slots).
// Input channel s_*: one beat per segment byte (cmd 0) or per table read
// (cmd 1); seg_start with cmd 0 marks byte 0 and restarts the parser.
// Output channel m_*: exactly one result beat per input beat, in order.
// A result reaches m_* through stage one, which takes the registered
// memory read, and then through the output register.
// Throughput: one beat per cycle as long as m_ready is high; each
// segment byte makes at most one memory write.
// Tables are written into the idle half of a two-bank memory and go live
// with a bank flip at the last byte, so a read always sees the last
// committed copy and an aborted table leaves the stored one untouched.
// Reset: parser idle, no table present; memories are not cleared and
// entries never written read back undefined.
// Stall: stage one and the output register hold two results; with both
// full and m_ready low, s_ready drops and resumes as m_ready returns.
`timescale 1ns / 1ps
`default_nettype none

`include "jpeg_huffman_table_segment_parser_defines.svh"

module jpeg_huffman_table_segment_parser #(
    parameter int TABLE_SLOTS = jhtsp_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_SYMBOLS = jhtsp_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire jhtsp_pkg::in_beat_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output jhtsp_pkg::out_beat_t      m_data
);
    import jhtsp_pkg::*;

    localparam int NT = 2 * TABLE_SLOTS;
    localparam int TW = $clog2(NT);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MARK2,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_CLASS,
        PH_COUNTS,
        PH_SYMBOLS
    } phase_t;

    // Parser state
    phase_t        phase_reg,   phase_next;
    logic [15:0]   rem_reg,     rem_next;
    logic [8:0]    pos_reg,     pos_next;
    logic [7:0]    len_hi_reg,  len_hi_next;
    logic [TW-1:0] tbl_reg,     tbl_next;
    logic          slot_ok_reg, slot_ok_next;
    logic [11:0]   total_reg,   total_next;

    // Pipeline
    logic          s1_valid_reg;
    logic [1:0]    s1_status_reg;
    logic [2:0]    s1_err_reg;
    logic          s1_kind_reg;
    logic          s1_val_ok_reg;
    logic          s1_pres_ok_reg;
    logic          out_valid_reg;
    out_beat_t     out_reg;
    out_beat_t     out_next;

    logic          accept;
    logic          s1_adv;
    logic [7:0]    b;
    logic [1:0]    st;
    logic [2:0]    err;
    logic          cnt_we;
    logic          sym_we;
    logic          commit;
    logic          finish;
    logic          end_chk;
    logic [15:0]   rem_end;
    logic [15:0]   len_total;
    logic [11:0]   cnt_sum;
    logic [8:0]    pos_inc;
    logic          cls_ok;
    logic [TW-1:0] cls_tbl;

    logic          rd_slot_ok;
    logic          rd_cnt_ok;
    logic          rd_sym_ok;
    logic [TW-1:0] rd_tbl;
    logic [7:0]    st_rd_cnt;
    logic [7:0]    st_rd_sym;
    logic          st_rd_present;
    store_ctl_t    ctl;

    // Handshake
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Byte-level helpers
    assign b         = s_data.seg_byte;
    assign len_total = {len_hi_reg, b};
    assign cnt_sum   = total_reg + {4'b0, b};
    assign pos_inc   = pos_reg + 9'd1;
    // Class byte: AC flag removed, every other bit must form a slot in range
    assign cls_ok    = (b[7:5] == 3'd0) && ({1'b0, b[3:0]} < 5'(TABLE_SLOTS));
    assign cls_tbl   = b[AC_BIT_POS] ? TW'(TABLE_SLOTS) + TW'(b[3:0]) : TW'(b[3:0]);

    // Parser next state and result code
    always_comb begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        len_hi_next  = len_hi_reg;
        tbl_next     = tbl_reg;
        slot_ok_next = slot_ok_reg;
        total_next   = total_reg;
        st           = ST_BUSY;
        err          = ERR_NONE;
        cnt_we       = 1'b0;
        sym_we       = 1'b0;
        commit       = 1'b0;
        finish       = 1'b0;
        end_chk      = 1'b0;
        rem_end      = rem_reg;

        if (s_data.cmd) begin
            st = ST_NOTE;
        end else if (s_data.seg_start) begin
            phase_next = PH_MARK2;
            rem_next   = '0;
            pos_next   = '0;
            total_next = '0;
        end else begin
            unique case (phase_reg)
                PH_MARK2: begin
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_hi_next = b;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (len_total < 16'(LEN_HDR)) begin
                        phase_next = PH_IDLE;
                        st         = ST_FAIL;
                        err        = ERR_SHORT_LEN;
                    end else begin
                        rem_end  = len_total - 16'(LEN_HDR);
                        rem_next = rem_end;
                        end_chk  = 1'b1;
                    end
                end
                PH_CLASS: begin
                    tbl_next     = cls_tbl;
                    slot_ok_next = cls_ok;
                    pos_next     = '0;
                    total_next   = '0;
                    phase_next   = PH_COUNTS;
                end
                PH_COUNTS: begin
                    cnt_we     = slot_ok_reg;
                    total_next = cnt_sum;
                    pos_next   = pos_inc;
                    if (pos_inc >= 9'(NUM_COUNTS)) begin
                        rem_end  = rem_reg - 16'(NUM_COUNTS + 1);
                        rem_next = rem_end;
                        if (cnt_sum > 12'(MAX_SYMBOLS)) begin
                            phase_next = PH_IDLE;
                            st         = ST_FAIL;
                            err        = ERR_TOO_MANY;
                        end else if ({4'b0, cnt_sum} > rem_end) begin
                            phase_next = PH_IDLE;
                            st         = ST_FAIL;
                            err        = ERR_OVERRUN;
                        end else if (cnt_sum == 12'd0) begin
                            finish = 1'b1;
                        end else begin
                            pos_next   = '0;
                            phase_next = PH_SYMBOLS;
                        end
                    end
                end
                PH_SYMBOLS: begin
                    sym_we   = slot_ok_reg;
                    pos_next = pos_inc;
                    if ({3'b0, pos_inc} >= total_reg) begin
                        rem_end  = rem_reg - {4'b0, total_reg};
                        rem_next = rem_end;
                        finish   = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    st         = ST_NOTE;
                end
            endcase

            // Table done: slot check, then commit
            if (finish) begin
                if (!slot_ok_reg) begin
                    phase_next = PH_IDLE;
                    st         = ST_FAIL;
                    err        = ERR_BAD_SLOT;
                end else begin
                    commit  = 1'b1;
                    end_chk = 1'b1;
                end
            end

            // What follows: another table, clean end, or stray bytes
            if (end_chk) begin
                if (rem_end > 16'(NUM_COUNTS)) begin
                    phase_next = PH_CLASS;
                end else if (rem_end == 16'd0) begin
                    phase_next = PH_IDLE;
                    st         = ST_DONE;
                end else begin
                    phase_next = PH_IDLE;
                    st         = ST_FAIL;
                    err        = ERR_TRAILING;
                end
            end
        end
    end

    // Read address decode
    assign rd_slot_ok = {1'b0, s_data.rd_slot} < 3'(TABLE_SLOTS);
    assign rd_cnt_ok  = (s_data.rd_pos != 8'd0) && ({1'b0, s_data.rd_pos} <= 9'(NUM_COUNTS));
    assign rd_sym_ok  = {1'b0, s_data.rd_pos} < 9'(MAX_SYMBOLS);
    always_comb begin
        rd_tbl = '0;
        if (rd_slot_ok) begin
            rd_tbl = s_data.rd_class ? TW'(TABLE_SLOTS) + TW'(s_data.rd_slot)
                                     : TW'(s_data.rd_slot);
        end
    end

    assign ctl.cnt_we = accept && cnt_we;
    assign ctl.sym_we = accept && sym_we;
    assign ctl.commit = accept && commit;
    assign ctl.rd_en  = accept && s_data.cmd;

    jhtsp_table_store #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .wr_tbl     (tbl_reg),
        .wr_cidx    (pos_reg[3:0]),
        .wr_spos    (pos_reg[7:0]),
        .wr_data    (b),
        .rd_tbl     (rd_tbl),
        .rd_cidx    (s_data.rd_pos[3:0] - 4'd1),
        .rd_spos    (s_data.rd_pos),
        .rd_cnt     (st_rd_cnt),
        .rd_sym     (st_rd_sym),
        .rd_present (st_rd_present)
    );

    // Result assembly from stage one and the memory read data
    always_comb begin
        out_next.status     = s1_status_reg;
        out_next.error_code = s1_err_reg;
        out_next.rd_value   = '0;
        if (s1_val_ok_reg) begin
            out_next.rd_value = s1_kind_reg ? st_rd_sym : st_rd_cnt;
        end
        out_next.rd_present = s1_pres_ok_reg && st_rd_present;
    end

    // Parser state and pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            rem_reg       <= '0;
            pos_reg       <= '0;
            len_hi_reg    <= '0;
            tbl_reg       <= '0;
            slot_ok_reg   <= 1'b0;
            total_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                rem_reg     <= rem_next;
                pos_reg     <= pos_next;
                len_hi_reg  <= len_hi_next;
                tbl_reg     <= tbl_next;
                slot_ok_reg <= slot_ok_next;
                total_reg   <= total_next;
            end
            s1_valid_reg  <= accept || (s1_valid_reg && !s1_adv);
            out_valid_reg <= s1_adv || (out_valid_reg && !m_ready);
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_status_reg  <= st;
            s1_err_reg     <= err;
            s1_kind_reg    <= s_data.rd_kind;
            s1_val_ok_reg  <= s_data.cmd && rd_slot_ok &&
                              (s_data.rd_kind ? rd_sym_ok : rd_cnt_ok);
            s1_pres_ok_reg <= s_data.cmd && rd_slot_ok;
        end
        if (s1_adv) begin
            out_reg <= out_next;
        end
    end

    `JHTSP_ASSERT_NXT(a_accept_fills_s1, accept, s1_valid_reg,
        "accepted beat lost before stage one")
    `JHTSP_ASSERT_IMP(a_class_has_room, phase_reg == PH_CLASS, rem_reg > 16'(NUM_COUNTS),
        "table header opened without room for counts")
    `JHTSP_ASSERT_IMP(a_counts_in_range, phase_reg == PH_COUNTS, pos_reg < 9'(NUM_COUNTS),
        "count index ran past sixteen")
    `JHTSP_ASSERT_IMP(a_symbols_in_range, phase_reg == PH_SYMBOLS,
        (total_reg <= 12'(MAX_SYMBOLS)) && ({3'b0, pos_reg} < total_reg),
        "symbol index outside the table")

endmodule

`default_nettype wire
